### rtl/core/mmed_pkg.sv
package mmed_pkg;

  // Widths fixed by the item and register fields
  localparam int SAMPLE_W   = 16;
  localparam int PERIOD_W   = 27;
  localparam int TIME_W     = 40;
  localparam int CELL_W     = 7;
  localparam int CELL_NUM_W = 6;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  // Defaults for the top-level parameters
  localparam int MAX_CELLS_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Items per cell when envelope pairs come in
  localparam int PAIR_CELL_ITEMS = 10;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SENTINEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_PER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_BK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_MODE    = 3'd4;

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_SAMPLE,
    KIND_END
  } kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sentinel;
    logic [PERIOD_W-1:0]        sample_period;
    logic [PERIOD_W-1:0]        cell_period;
    logic [CELL_W-1:0]          cells_per_block;
    logic                       pair_mode;
  } cfg_t;

  // One classified item in the queue between front and back
  typedef struct packed {
    kind_t                      kind;
    logic [PERIOD_W-1:0]        start_time;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic                       skip;
  } qitem_t;

endpackage

### rtl/core/mmed_front.sv
module mmed_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mmed_pkg::CMD_W-1:0]       in_cmd,
  input  logic [mmed_pkg::PERIOD_W-1:0]    in_phase,
  input  logic [mmed_pkg::SAMPLE_W-1:0]    in_low,
  input  logic [mmed_pkg::SAMPLE_W-1:0]    in_high,
  input  mmed_pkg::cfg_t                   cfg,
  input  logic                             q_full,
  output logic                             q_push,
  output mmed_pkg::qitem_t                 q_item
);
  import mmed_pkg::*;

  logic block_open;
  logic block_open_next;
  logic accept;
  logic signed [SAMPLE_W-1:0] hi_sel;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Resolve the pair value and the skip flag up front
  assign hi_sel = cfg.pair_mode ? $signed(in_high) : $signed(in_low);

  always_comb begin
    q_item.kind       = KIND_SAMPLE;
    q_item.start_time = cfg.pair_mode ? '0 : in_phase;
    q_item.lo         = $signed(in_low);
    q_item.hi         = hi_sel;
    q_item.skip       = ($signed(in_low) == cfg.sentinel) || (hi_sel == cfg.sentinel);
    q_push            = 1'b0;
    block_open_next   = block_open;
    if (accept) begin
      unique case (in_cmd)
        CMD_BEGIN: begin
          q_item.kind     = KIND_BEGIN;
          q_push          = 1'b1;
          block_open_next = 1'b1;
        end
        CMD_SAMPLE: begin
          q_push = block_open;
        end
        CMD_END: begin
          q_item.kind     = KIND_END;
          q_push          = block_open;
          block_open_next = 1'b0;
        end
        default: begin
          // unknown command: drop
        end
      endcase
    end
  end

  // Track whether a block is open so stray items never reach the back
  always_ff @(posedge clk) begin
    if (rst) begin
      block_open <= 1'b0;
    end else begin
      block_open <= block_open_next;
    end
  end

endmodule

### rtl/core/mmed_queue.sv
module mmed_queue #(
  parameter int DEPTH = mmed_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mmed_pkg::qitem_t push_item,
  output logic             full,
  input  logic             pop,
  output mmed_pkg::qitem_t head,
  output logic             empty
);
  import mmed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  qitem_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/mmed_back.sv
module mmed_back #(
  parameter int MAX_CELLS = mmed_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mmed_pkg::cfg_t                     cfg,
  input  mmed_pkg::qitem_t                   head,
  input  logic                               q_empty,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mmed_pkg::SAMPLE_W-1:0] out_min,
  output logic signed [mmed_pkg::SAMPLE_W-1:0] out_max,
  output logic [mmed_pkg::CELL_NUM_W-1:0]    out_num,
  output logic                               out_last
);
  import mmed_pkg::*;

  localparam logic [CELL_W-1:0]   MAX_TOTAL = CELL_W'(MAX_CELLS);
  localparam logic [PERIOD_W-1:0] PAIR_SPAN = PERIOD_W'(PAIR_CELL_ITEMS);
  localparam logic [PERIOD_W-1:0] PAIR_STEP = PERIOD_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                     state;
  qitem_t                     item;
  logic [CELL_W-1:0]          cur;
  logic [TIME_W-1:0]          stime;
  logic [TIME_W-1:0]          cend;
  logic signed [SAMPLE_W-1:0] rmin;
  logic signed [SAMPLE_W-1:0] rmax;

  logic [CELL_W-1:0]   total;
  logic [PERIOD_W-1:0] span;
  logic [PERIOD_W-1:0] step;
  logic                in_range;
  logic                want_emit;
  logic                slot_free;
  logic                emit;
  logic                done;
  logic [TIME_W:0]     cend_sum;
  logic [TIME_W:0]     stime_sum;
  logic [TIME_W-1:0]   cend_adv;
  logic [TIME_W-1:0]   stime_adv;
  logic [CELL_W-1:0]   cur_inc;

  // Per-item constants from the configuration
  assign total = (cfg.cells_per_block > MAX_TOTAL) ? MAX_TOTAL : cfg.cells_per_block;
  assign span  = cfg.pair_mode ? PAIR_SPAN : cfg.cell_period;
  assign step  = cfg.pair_mode ? PAIR_STEP : cfg.sample_period;

  // Boundary check: an end item flushes, a sample only flushes crossed cells
  assign in_range  = (cur < total);
  assign want_emit = (item.kind == KIND_END) ? in_range : (in_range && (stime >= cend));
  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == ST_RUN) && want_emit && slot_free;
  assign done      = (state == ST_RUN) && !want_emit;
  assign q_pop     = (state == ST_IDLE) && !q_empty;

  // Saturating time arithmetic
  assign cend_sum  = {1'b0, cend} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, span};
  assign stime_sum = {1'b0, stime} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, step};
  assign cend_adv  = cend_sum[TIME_W] ? '1 : cend_sum[TIME_W-1:0];
  assign stime_adv = stime_sum[TIME_W] ? '1 : stime_sum[TIME_W-1:0];
  assign cur_inc   = cur + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Release the output register once taken
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (head.kind == KIND_BEGIN) begin
              // Open a new block, dropping any unfinished one
              cur   <= '0;
              stime <= {{(TIME_W - PERIOD_W){1'b0}}, head.start_time};
              cend  <= {{(TIME_W - PERIOD_W){1'b0}}, span};
              rmin  <= cfg.sentinel;
              rmax  <= cfg.sentinel;
            end else begin
              item  <= head;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (emit) begin
            // Emit the current cell and move to the next
            out_valid <= 1'b1;
            out_min   <= rmin;
            out_max   <= rmax;
            out_num   <= cur[CELL_NUM_W-1:0];
            out_last  <= (cur_inc == total);
            rmin      <= cfg.sentinel;
            rmax      <= cfg.sentinel;
            cur       <= cur_inc;
            cend      <= cend_adv;
          end else if (done) begin
            if (item.kind == KIND_SAMPLE) begin
              // Fold the sample into the running envelope
              if (in_range && !item.skip) begin
                if ((rmin == cfg.sentinel) || (item.lo < rmin)) begin
                  rmin <= item.lo;
                end
                if ((rmax == cfg.sentinel) || (item.hi > rmax)) begin
                  rmax <= item.hi;
                end
              end
              stime <= stime_adv;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/min_max_envelope_decimator.sv
// Min/max envelope decimator.
// Input items arrive on the s_axis channel: tuser carries the command
// (begin block, sample, end of block), tdata the phase offset and the sample
// value or low/high pair. Each finished cell leaves on the m_axis channel as
// one item with its minimum, maximum and cell number in tdata; tlast marks
// the final cell of the block. Registers are written through the cfg channel
// (always ready) and must only change while the block is idle.
// A front stage classifies items and drops those outside a block; a short
// queue decouples it from the back stage, which walks cell boundaries.
// In the back stage a begin item is handled in the idle state; a sample item
// emits one cell per cell boundary it crosses, and an end item one cell per
// remaining cell, before the stage returns to idle. The first cell of an item
// passes the queue slot and the item register before the m_axis output register.
// When m_axis stalls, the back stage holds its current cell while the front
// keeps taking items until the queue is full. Reset (rst, synchronous)
// closes any open block, empties the queue and output, and restores the
// register defaults.
module min_max_envelope_decimator #(
  parameter int MAX_CELLS   = mmed_pkg::MAX_CELLS_DEF,
  parameter int QUEUE_DEPTH = mmed_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // phase_offset[26:0], sample_low[42:27], sample_high[58:43], zero pad
  input  logic [mmed_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  logic [mmed_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cell_min[15:0], cell_max[31:16], cell_number[37:32], zero pad
  output logic [mmed_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // last_cell
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mmed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmed_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mmed_pkg::*;

  cfg_t   cfg;
  qitem_t push_item;
  qitem_t head;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  logic signed [SAMPLE_W-1:0] out_min;
  logic signed [SAMPLE_W-1:0] out_max;
  logic [CELL_NUM_W-1:0]      out_num;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sentinel        <= 16'sh8000;
      cfg.sample_period   <= PERIOD_W'(1000);
      cfg.cell_period     <= PERIOD_W'(10000);
      cfg.cells_per_block <= CELL_W'(64);
      cfg.pair_mode       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENTINEL:     cfg.sentinel        <= $signed(cfg_data[SAMPLE_W-1:0]);
        REG_SAMPLE_PER:   cfg.sample_period   <= cfg_data[PERIOD_W-1:0];
        REG_CELL_PER:     cfg.cell_period     <= cfg_data[PERIOD_W-1:0];
        REG_CELLS_PER_BK: cfg.cells_per_block <= cfg_data[CELL_W-1:0];
        REG_PAIR_MODE:    cfg.pair_mode       <= cfg_data[0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  mmed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_phase (s_axis_tdata[26:0]),
    .in_low   (s_axis_tdata[42:27]),
    .in_high  (s_axis_tdata[58:43]),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  mmed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  mmed_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_min   (out_min),
    .out_max   (out_max),
    .out_num   (out_num),
    .out_last  (m_axis_tlast)
  );

  // Pack the result item
  assign m_axis_tdata = {2'b00, out_num, out_max, out_min};

endmodule
